// ===== sv/iirfb_pkg.sv =====
// Shared widths, register indexes, sequencer codes and rounding functions for the IIR filter bank.
`timescale 1ns / 1ps

package iirfb_pkg;

	// Field and datapath widths.
	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 16;
	localparam int SIG_W    = 24;
	localparam int PROD_W   = COEF_W + SIG_W;
	localparam int ACC_W    = PROD_W + 2;
	localparam int FRAC_X   = 8;
	localparam int COEF_FRAC = 14;
	localparam int OUT_SUM_W = SIG_W + 2;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_LP_B0 = 3'd0;
	localparam logic [2:0] REG_LP_B1 = 3'd1;
	localparam logic [2:0] REG_LP_A1 = 3'd2;
	localparam logic [2:0] REG_HP_B0 = 3'd3;
	localparam logic [2:0] REG_HP_B1 = 3'd4;
	localparam logic [2:0] REG_HP_A1 = 3'd5;

	// Reset values of the coefficients, Q2.14.
	localparam logic signed [COEF_W-1:0] RST_LP_B0 = 16'sd499;
	localparam logic signed [COEF_W-1:0] RST_LP_B1 = 16'sd499;
	localparam logic signed [COEF_W-1:0] RST_LP_A1 = -16'sd15386;
	localparam logic signed [COEF_W-1:0] RST_HP_B0 = 16'sd15885;
	localparam logic signed [COEF_W-1:0] RST_HP_B1 = -16'sd15885;
	localparam logic signed [COEF_W-1:0] RST_HP_A1 = -16'sd15386;

	// Section order followed by the sequencer.
	localparam logic [2:0] SEC_LP  = 3'd0;
	localparam logic [2:0] SEC_HP  = 3'd1;
	localparam logic [2:0] SEC_LP2 = 3'd2;
	localparam logic [2:0] SEC_HP2 = 3'd3;
	localparam logic [2:0] SEC_BP  = 3'd4;

	// Product terms within one section.
	localparam logic [1:0] TERM_B0 = 2'd0;
	localparam logic [1:0] TERM_B1 = 2'd1;
	localparam logic [1:0] TERM_A1 = 2'd2;

	// Half of one Q16.8 step at Q22, the rounding offset of a section.
	localparam logic signed [ACC_W-1:0] SEC_ROUND = ACC_W'(1 << (COEF_FRAC - 1));
	// Half of one integer step at Q16.8.
	localparam logic signed [OUT_SUM_W-1:0] OUT_ROUND = OUT_SUM_W'(1 << (FRAC_X - 1));

	// Floor shift of the Q22 sum to Q16.8 and saturation to the signal width.
	function automatic logic signed [SIG_W-1:0] sat_section(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-COEF_FRAC-1:0] sh;
		logic                              ovf;
		sh  = a[ACC_W-1:COEF_FRAC];
		ovf = (sh[ACC_W-COEF_FRAC-1:SIG_W-1] != {(ACC_W-COEF_FRAC-SIG_W+1){1'b0}}) &&
		      (sh[ACC_W-COEF_FRAC-1:SIG_W-1] != {(ACC_W-COEF_FRAC-SIG_W+1){1'b1}});
		if (ovf) begin
			return sh[ACC_W-COEF_FRAC-1] ? {1'b1, {(SIG_W-1){1'b0}}} : {1'b0, {(SIG_W-1){1'b1}}};
		end
		return sh[SIG_W-1:0];
	endfunction

	// Round half up from Q16.8 to an integer and saturate to the sample width.
	function automatic logic signed [SAMPLE_W-1:0] to_out(input logic signed [OUT_SUM_W-1:0] v);
		logic signed [OUT_SUM_W-1:0]        sum;
		logic signed [OUT_SUM_W-FRAC_X-1:0] sh;
		logic                               ovf;
		sum = v + OUT_ROUND;
		sh  = sum[OUT_SUM_W-1:FRAC_X];
		ovf = (sh[OUT_SUM_W-FRAC_X-1:SAMPLE_W-1] != {(OUT_SUM_W-FRAC_X-SAMPLE_W+1){1'b0}}) &&
		      (sh[OUT_SUM_W-FRAC_X-1:SAMPLE_W-1] != {(OUT_SUM_W-FRAC_X-SAMPLE_W+1){1'b1}});
		if (ovf) begin
			return sh[OUT_SUM_W-FRAC_X-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
			                              : {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
		return sh[SAMPLE_W-1:0];
	endfunction

endpackage

// ===== sv/first_order_iir_filter_bank_top.sv =====
// Bank of five first-order IIR sections sharing one multiplier, with APB coefficient registers.
`timescale 1ns / 1ps

// One signed 16-bit sample per request yields eight outputs: the sample itself, low-pass,
// high-pass, all-pass (high minus low), cascaded low-pass and high-pass, band-pass (high-pass
// of the low-pass, doubled) and band-stop (sum of the cascaded pair). A single 16x24 multiplier
// and accumulator work through the fifteen products of the five sections one per cycle, so
// a request passes through the products, a drain of the accumulator, the rounding of the
// outputs once the result register is free and a return to idle before the next sample can
// be accepted. The result is held in an output register; the next sample may be taken while
// it waits. Coefficients are Q2.14 at byte addresses 0 to 20 and should be written only
// while the block is idle.
module first_order_iir_filter_bank_top
	import iirfb_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	// APB-style configuration port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [4:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	// Sample channel
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample,
	// Result channel
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] raw_out,
	output logic signed [SAMPLE_W-1:0] highpass_out,
	output logic signed [SAMPLE_W-1:0] lowpass_out,
	output logic signed [SAMPLE_W-1:0] allpass_out,
	output logic signed [SAMPLE_W-1:0] highpass2_out,
	output logic signed [SAMPLE_W-1:0] lowpass2_out,
	output logic signed [SAMPLE_W-1:0] bandpass_out,
	output logic signed [SAMPLE_W-1:0] bandstop_out
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MUL   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [2:0] sec_q;
	logic [1:0] term_q;

	logic signed [COEF_W-1:0] lp_b0_q, lp_b1_q, lp_a1_q;
	logic signed [COEF_W-1:0] hp_b0_q, hp_b1_q, hp_a1_q;

	logic signed [SAMPLE_W-1:0] sample_q, last_in_q;
	logic signed [SIG_W-1:0]    last_lp_q, last_hp_q, last_lp2_q, last_hp2_q, last_bp_q;
	logic signed [SIG_W-1:0]    lp_res_q, hp_res_q, lp2_res_q, hp2_res_q, bp_res_q;

	logic signed [COEF_W-1:0] coef_sel;
	logic signed [SIG_W-1:0]  data_sel;

	logic signed [PROD_W-1:0] prod_s1;
	logic                     valid_s1, sub_s1, first_s1, last_s1;
	logic [2:0]               sec_s1;

	logic signed [ACC_W-1:0] acc_q, acc_base, prod_ext, acc_next;
	logic signed [SIG_W-1:0] sec_result;

	logic [2:0] wr_index;
	logic       cfg_wr;
	logic       in_acc, out_free;

	assign pready   = 1'b1;
	assign wr_index = paddr[4:2];
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;

	// Coefficient registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_b0_q <= RST_LP_B0;
			lp_b1_q <= RST_LP_B1;
			lp_a1_q <= RST_LP_A1;
			hp_b0_q <= RST_HP_B0;
			hp_b1_q <= RST_HP_B1;
			hp_a1_q <= RST_HP_A1;
		end else if (cfg_wr) begin
			unique case (wr_index)
				REG_LP_B0: lp_b0_q <= pwdata[COEF_W-1:0];
				REG_LP_B1: lp_b1_q <= pwdata[COEF_W-1:0];
				REG_LP_A1: lp_a1_q <= pwdata[COEF_W-1:0];
				REG_HP_B0: hp_b0_q <= pwdata[COEF_W-1:0];
				REG_HP_B1: hp_b1_q <= pwdata[COEF_W-1:0];
				REG_HP_A1: hp_a1_q <= pwdata[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read-back, sign-extended to the bus.
	always_comb begin
		unique case (wr_index)
			REG_LP_B0: prdata = 32'(lp_b0_q);
			REG_LP_B1: prdata = 32'(lp_b1_q);
			REG_LP_A1: prdata = 32'(lp_a1_q);
			REG_HP_B0: prdata = 32'(hp_b0_q);
			REG_HP_B1: prdata = 32'(hp_b1_q);
			REG_HP_A1: prdata = 32'(hp_a1_q);
			default:   prdata = '0;
		endcase
	end

	// Operand selection for the product now being issued.
	always_comb begin
		coef_sel = '0;
		data_sel = '0;
		case (sec_q) inside
			SEC_LP, SEC_LP2: begin
				case (term_q)
					TERM_B0: coef_sel = lp_b0_q;
					TERM_B1: coef_sel = lp_b1_q;
					default: coef_sel = lp_a1_q;
				endcase
			end
			SEC_HP, SEC_HP2, SEC_BP: begin
				case (term_q)
					TERM_B0: coef_sel = hp_b0_q;
					TERM_B1: coef_sel = hp_b1_q;
					default: coef_sel = hp_a1_q;
				endcase
			end
			default: coef_sel = '0;
		endcase
		case (term_q)
			TERM_B0: begin
				case (sec_q) inside
					SEC_LP, SEC_HP:  data_sel = {sample_q, {FRAC_X{1'b0}}};
					SEC_LP2, SEC_BP: data_sel = lp_res_q;
					SEC_HP2:         data_sel = hp_res_q;
					default:         data_sel = '0;
				endcase
			end
			TERM_B1: begin
				case (sec_q) inside
					SEC_LP, SEC_HP:  data_sel = {last_in_q, {FRAC_X{1'b0}}};
					SEC_LP2, SEC_BP: data_sel = last_lp_q;
					SEC_HP2:         data_sel = last_hp_q;
					default:         data_sel = '0;
				endcase
			end
			default: begin
				case (sec_q)
					SEC_LP:  data_sel = last_lp_q;
					SEC_HP:  data_sel = last_hp_q;
					SEC_LP2: data_sel = last_lp2_q;
					SEC_HP2: data_sel = last_hp2_q;
					SEC_BP:  data_sel = last_bp_q;
					default: data_sel = '0;
				endcase
			end
		endcase
	end

	// Sequencer: issues the fifteen products, drains, then hands over the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			sec_q    <= SEC_LP;
			term_q   <= TERM_B0;
			valid_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					valid_s1 <= 1'b0;
					if (in_acc) begin
						sec_q   <= SEC_LP;
						term_q  <= TERM_B0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					valid_s1 <= 1'b1;
					if (term_q == TERM_A1) begin
						term_q <= TERM_B0;
						sec_q  <= sec_q + 3'd1;
						if (sec_q == SEC_BP) begin
							state_q <= ST_DRAIN;
						end
					end else begin
						term_q <= term_q + 2'd1;
					end
				end
				ST_DRAIN: begin
					valid_s1 <= 1'b0;
					state_q  <= ST_DONE;
				end
				ST_DONE: begin
					valid_s1 <= 1'b0;
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result valid: raised on leaving the hand-over state, dropped once the result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// Shared multiplier stage.
	always_ff @(posedge clk) begin
		prod_s1  <= PROD_W'(coef_sel) * PROD_W'(data_sel);
		sub_s1   <= (term_q == TERM_A1);
		first_s1 <= (term_q == TERM_B0);
		last_s1  <= (term_q == TERM_A1);
		sec_s1   <= sec_q;
	end

	// Accumulator; each section starts from the rounding offset.
	assign acc_base   = first_s1 ? SEC_ROUND : acc_q;
	assign prod_ext   = ACC_W'(prod_s1);
	assign acc_next   = sub_s1 ? (acc_base - prod_ext) : (acc_base + prod_ext);
	assign sec_result = sat_section(acc_next);

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			acc_q <= acc_next;
			if (last_s1) begin
				case (sec_s1)
					SEC_LP:  lp_res_q  <= sec_result;
					SEC_HP:  hp_res_q  <= sec_result;
					SEC_LP2: lp2_res_q <= sec_result;
					SEC_HP2: hp2_res_q <= sec_result;
					SEC_BP:  bp_res_q  <= sec_result;
					default: ;
				endcase
			end
		end
	end

	// Captured sample.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_q <= sample;
		end
	end

	// Filter history, advanced once all sections of a request are done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_in_q  <= '0;
			last_lp_q  <= '0;
			last_hp_q  <= '0;
			last_lp2_q <= '0;
			last_hp2_q <= '0;
			last_bp_q  <= '0;
		end else if (state_q == ST_DONE && out_free) begin
			last_in_q  <= sample_q;
			last_lp_q  <= lp_res_q;
			last_hp_q  <= hp_res_q;
			last_lp2_q <= lp2_res_q;
			last_hp2_q <= hp2_res_q;
			last_bp_q  <= bp_res_q;
		end
	end

	// Output rounding and combinations into the result register.
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			raw_out       <= sample_q;
			highpass_out  <= to_out(OUT_SUM_W'(hp_res_q));
			lowpass_out   <= to_out(OUT_SUM_W'(lp_res_q));
			allpass_out   <= to_out(OUT_SUM_W'(hp_res_q) - OUT_SUM_W'(lp_res_q));
			highpass2_out <= to_out(OUT_SUM_W'(hp2_res_q));
			lowpass2_out  <= to_out(OUT_SUM_W'(lp2_res_q));
			bandpass_out  <= to_out(OUT_SUM_W'(bp_res_q) <<< 1);
			bandstop_out  <= to_out(OUT_SUM_W'(lp2_res_q) + OUT_SUM_W'(hp2_res_q));
		end
	end

`ifndef SYNTHESIS
	// A new result appears only on leaving the hand-over state.
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == ST_DONE))
		else $error("result raised outside hand-over");

	// An accepted sample starts the sequence at its first product.
	a_start_seq: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_MUL && sec_q == SEC_LP && term_q == TERM_B0))
		else $error("sequence did not start at the first product");

	// The multiplier stage carries work only while products are issued or drained.
	a_s1_window: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q == ST_MUL || state_q == ST_DRAIN))
		else $error("product in flight outside the multiply window");

	// The drain cycle always follows the last product of the band-pass section.
	a_drain_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (valid_s1 && last_s1 && sec_s1 == SEC_BP))
		else $error("drain without the final product");
`endif

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the IIR filter bank: directed and random samples under changing coefficients.
`timescale 1ns / 1ps

module tb
	import iirfb_pkg::*;
();

	// Coefficient settings used between test phases.
	typedef enum int {
		CSET_RESET, CSET_UNITY, CSET_ZERO, CSET_MAX, CSET_MIN, CSET_STABLE, CSET_WILD
	} coef_set_t;

	// The eight views of one sample, raw_out at index 0.
	typedef logic [7:0][SAMPLE_W-1:0] views_t;

	typedef struct {
		coef_set_t                  cset;
		logic signed [SAMPLE_W-1:0] smp;
		bit                         known;
		views_t                     typed;
	} stim_row_t;

	// Register indexes past the end of the register file.
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	localparam int NUM_COEFS    = 6;
	localparam int IDLE_PCT     = 16;
	localparam int RAND_PHASES  = 10;
	localparam int PHASE_ITEMS  = 190;
	localparam int HOLD_PHASE   = 2;
	localparam int QUIET_PHASE  = 3;
	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE_SHORT = 4;
	localparam int SETTLE_END   = 40;
	localparam int STALL_LIMIT  = 4000;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       psel      = 1'b0;
	logic                       penable   = 1'b0;
	logic                       pwrite    = 1'b0;
	logic [4:0]                 paddr     = '0;
	logic [31:0]                pwdata    = '0;
	logic [31:0]                prdata;
	logic                       pready;
	logic                       in_valid  = 1'b0;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample    = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] raw_out;
	logic signed [SAMPLE_W-1:0] highpass_out;
	logic signed [SAMPLE_W-1:0] lowpass_out;
	logic signed [SAMPLE_W-1:0] allpass_out;
	logic signed [SAMPLE_W-1:0] highpass2_out;
	logic signed [SAMPLE_W-1:0] lowpass2_out;
	logic signed [SAMPLE_W-1:0] bandpass_out;
	logic signed [SAMPLE_W-1:0] bandstop_out;

	first_order_iir_filter_bank_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample       (sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.raw_out      (raw_out),
		.highpass_out (highpass_out),
		.lowpass_out  (lowpass_out),
		.allpass_out  (allpass_out),
		.highpass2_out(highpass2_out),
		.lowpass2_out (lowpass2_out),
		.bandpass_out (bandpass_out),
		.bandstop_out (bandstop_out)
	);

	string view_name [8] = '{"raw_out", "highpass_out", "lowpass_out", "allpass_out",
	                         "highpass2_out", "lowpass2_out", "bandpass_out", "bandstop_out"};

	// Coefficients as last written, and the filter history they act on.
	logic signed [COEF_W-1:0]   coefs [NUM_COEFS] = '{RST_LP_B0, RST_LP_B1, RST_LP_A1,
	                                                  RST_HP_B0, RST_HP_B1, RST_HP_A1};
	logic signed [SAMPLE_W-1:0] prev_sample = '0;
	logic signed [SIG_W-1:0]    prev_lp     = '0;
	logic signed [SIG_W-1:0]    prev_hp     = '0;
	logic signed [SIG_W-1:0]    prev_lp2    = '0;
	logic signed [SIG_W-1:0]    prev_hp2    = '0;
	logic signed [SIG_W-1:0]    prev_bp     = '0;

	views_t    expected_views [$];
	coef_set_t active_set       = CSET_RESET;
	int        gap_pct          = IDLE_PCT;
	int        stall_pct        = IDLE_PCT;
	bit        hold_req         = 1'b0;
	int        hold_left        = 0;
	int        idle_cycles      = 0;
	int        mismatches       = 0;
	int        samples_sent     = 0;
	int        results_checked  = 0;
	int        settings_loaded  = 0;

	// Directed samples: the coefficient setting each needs, and the result where it is obvious.
	stim_row_t directed_rows [25] = '{
		'{CSET_RESET,  16'sd0,      1'b1, '0},
		'{CSET_RESET,  16'sh7FFF,   1'b0, '0},
		'{CSET_RESET,  16'sh7FFF,   1'b0, '0},
		'{CSET_RESET,  16'sh8000,   1'b0, '0},
		'{CSET_RESET,  16'sh8000,   1'b0, '0},
		'{CSET_RESET,  16'sd1,      1'b0, '0},
		'{CSET_RESET,  16'shFFFF,   1'b0, '0},
		'{CSET_RESET,  16'sh5555,   1'b0, '0},
		'{CSET_RESET,  16'shAAAA,   1'b0, '0},
		'{CSET_UNITY,  16'sh7FFF,   1'b1, {16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
		                                   16'sh0000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}},
		'{CSET_UNITY,  16'sh8000,   1'b1, {16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
		                                   16'sh0000, 16'sh8000, 16'sh8000, 16'sh8000}},
		'{CSET_UNITY,  16'sd100,    1'b1, {16'sd200, 16'sd200, 16'sd100, 16'sd100,
		                                   16'sd0, 16'sd100, 16'sd100, 16'sd100}},
		'{CSET_UNITY,  16'shFFFF,   1'b1, {16'shFFFE, 16'shFFFE, 16'shFFFF, 16'shFFFF,
		                                   16'sh0000, 16'shFFFF, 16'shFFFF, 16'shFFFF}},
		'{CSET_ZERO,   16'sd12345,  1'b1, {16'sd0, 16'sd0, 16'sd0, 16'sd0,
		                                   16'sd0, 16'sd0, 16'sd0, 16'sd12345}},
		'{CSET_ZERO,   16'sh8000,   1'b1, {16'sd0, 16'sd0, 16'sd0, 16'sd0,
		                                   16'sd0, 16'sd0, 16'sd0, 16'sh8000}},
		'{CSET_MAX,    16'sh7FFF,   1'b0, '0},
		'{CSET_MAX,    16'sh7FFF,   1'b0, '0},
		'{CSET_MAX,    16'sh8000,   1'b0, '0},
		'{CSET_MAX,    16'sd0,      1'b0, '0},
		'{CSET_MAX,    16'sd0,      1'b0, '0},
		'{CSET_MIN,    16'sh7FFF,   1'b0, '0},
		'{CSET_MIN,    16'sh8000,   1'b0, '0},
		'{CSET_MIN,    16'sd0,      1'b0, '0},
		'{CSET_MIN,    16'sd0,      1'b0, '0},
		'{CSET_RESET,  16'sd0,      1'b0, '0}
	};

	// Free-running clock, 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// One first-order section on Q16.8 signals: exact Q22 sum, rounded half up, saturated.
	function automatic logic signed [SIG_W-1:0] run_section(
		input logic signed [COEF_W-1:0] b0, b1, a1,
		input longint x, xp, yp);
		longint acc;
		acc = longint'(b0) * x + longint'(b1) * xp - longint'(a1) * yp;
		acc = (acc + 64'sd8192) >>> COEF_FRAC;
		if (acc > longint'((1 << (SIG_W - 1)) - 1))
			acc = (1 << (SIG_W - 1)) - 1;
		else if (acc < -longint'(1 << (SIG_W - 1)))
			acc = -longint'(1 << (SIG_W - 1));
		return acc[SIG_W-1:0];
	endfunction

	// Q16.8 value to a saturated 16-bit integer, rounding half up.
	function automatic logic signed [SAMPLE_W-1:0] round_view(input longint v);
		v = (v + 64'sd128) >>> FRAC_X;
		if (v > 32767)
			v = 32767;
		else if (v < -32768)
			v = -32768;
		return v[SAMPLE_W-1:0];
	endfunction

	// Advance the filter history by one sample and return the eight views it yields.
	function automatic views_t filter_bank_step(input logic signed [SAMPLE_W-1:0] s);
		longint                  x, xp;
		logic signed [SIG_W-1:0] lp, hp, lp2, hp2, bp;
		x   = longint'(s) * 256;
		xp  = longint'(prev_sample) * 256;
		lp  = run_section(coefs[REG_LP_B0], coefs[REG_LP_B1], coefs[REG_LP_A1],
		                  x, xp, longint'(prev_lp));
		hp  = run_section(coefs[REG_HP_B0], coefs[REG_HP_B1], coefs[REG_HP_A1],
		                  x, xp, longint'(prev_hp));
		lp2 = run_section(coefs[REG_LP_B0], coefs[REG_LP_B1], coefs[REG_LP_A1],
		                  longint'(lp), longint'(prev_lp), longint'(prev_lp2));
		hp2 = run_section(coefs[REG_HP_B0], coefs[REG_HP_B1], coefs[REG_HP_A1],
		                  longint'(hp), longint'(prev_hp), longint'(prev_hp2));
		bp  = run_section(coefs[REG_HP_B0], coefs[REG_HP_B1], coefs[REG_HP_A1],
		                  longint'(lp), longint'(prev_lp), longint'(prev_bp));
		prev_sample = s;
		prev_lp     = lp;
		prev_hp     = hp;
		prev_lp2    = lp2;
		prev_hp2    = hp2;
		prev_bp     = bp;
		return {round_view(longint'(lp2) + longint'(hp2)), round_view(2 * longint'(bp)),
		        round_view(longint'(lp2)), round_view(longint'(hp2)),
		        round_view(longint'(hp) - longint'(lp)),
		        round_view(longint'(lp)), round_view(longint'(hp)), s};
	endfunction

	// One APB transfer: setup phase, then access until pready. The bus is left selected.
	task automatic apb_access(input logic wr, input logic [4:0] addr, input logic [31:0] wdata,
	                          output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
	endtask

	// Write a coefficient setting, poke a spare address, then read the registers back.
	task automatic load_coefs(input coef_set_t cs);
		logic signed [COEF_W-1:0] c [NUM_COEFS];
		logic [31:0]              rd;
		int                       b;
		case (cs)
			CSET_RESET: begin
				c = '{RST_LP_B0, RST_LP_B1, RST_LP_A1, RST_HP_B0, RST_HP_B1, RST_HP_A1};
			end
			CSET_UNITY: begin
				c = '{default: '0};
				c[REG_LP_B0] = 16'sd16384;
				c[REG_HP_B0] = 16'sd16384;
			end
			CSET_ZERO: c = '{default: '0};
			CSET_MAX:  c = '{default: 16'sh7FFF};
			CSET_MIN:  c = '{default: 16'sh8000};
			CSET_STABLE: begin
				b = $urandom_range(4000);
				c[REG_LP_B0] = 16'(b);
				c[REG_LP_B1] = 16'(b);
				c[REG_LP_A1] = 16'(2 * b - 16384);
				b = $urandom_range(16383, 8000);
				c[REG_HP_B0] = 16'(b);
				c[REG_HP_B1] = 16'(-b);
				c[REG_HP_A1] = 16'(-int'($urandom_range(16383, 8000)));
			end
			default: begin
				foreach (c[r])
					c[r] = 16'($urandom);
			end
		endcase
		for (int r = 0; r < NUM_COEFS; r++) begin
			apb_access(1'b1, 5'(r * 4), {{16{c[r][COEF_W-1]}}, c[r]}, rd);
			coefs[r] = c[r];
		end
		// A write past the last register must leave the file untouched.
		apb_access(1'b1, {($urandom_range(1) != 0) ? REG_SPARE_HI : REG_SPARE_LO, 2'b00},
		           $urandom, rd);
		for (int r = 0; r < NUM_COEFS; r++) begin
			apb_access(1'b0, 5'(r * 4), '0, rd);
			if (rd[COEF_W-1:0] !== coefs[r]) begin
				$error("prdata of register %0d: expected %0d, actual %0d",
				       r, coefs[r], $signed(rd[COEF_W-1:0]));
				mismatches++;
			end
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		active_set = cs;
		settings_loaded++;
	endtask

	// Offer one sample, with a random gap first, and predict its views once it is taken.
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input bit known,
	                           input views_t typed);
		views_t predicted;
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predicted = filter_bank_step(s);
		expected_views.push_back(known ? typed : predicted);
		samples_sent++;
	endtask

	// Wait until every expected result has arrived, then let the block go quiet.
	task automatic settle(input int cycles);
		in_valid <= 1'b0;
		while (expected_views.size() != 0) @(posedge clk);
		repeat (cycles) @(posedge clk);
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	always @(posedge clk) begin
		if (hold_req && hold_left == 0) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		views_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {bandstop_out, bandpass_out, lowpass2_out, highpass2_out,
			       allpass_out, lowpass_out, highpass_out, raw_out};
			if (expected_views.size() == 0) begin
				$error("result accepted with no request outstanding");
				mismatches++;
			end else begin
				want = expected_views.pop_front();
				for (int f = 0; f < 8; f++) begin
					if (got[f] !== want[f]) begin
						$error("%s: expected %0d, actual %0d",
						       view_name[f], $signed(want[f]), $signed(got[f]));
						mismatches++;
					end
				end
				results_checked++;
			end
		end
	end

	// Watchdog on cycles in which neither channel moves.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Stimulus: reset, directed table, then random phases under fresh coefficients.
	initial begin
		logic signed [SAMPLE_W-1:0] s;
		coef_set_t                  cs;
		s = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].cset != active_set) begin
				settle(SETTLE_SHORT);
				load_coefs(directed_rows[i].cset);
			end
			send_sample(directed_rows[i].smp, directed_rows[i].known, directed_rows[i].typed);
		end

		for (int p = 0; p < RAND_PHASES; p++) begin
			settle(SETTLE_SHORT);
			case ($urandom_range(3))
				0:       cs = CSET_RESET;
				1:       cs = CSET_WILD;
				default: cs = CSET_STABLE;
			endcase
			load_coefs(cs);
			gap_pct   = (p == QUIET_PHASE) ? 0 : IDLE_PCT;
			stall_pct = (p == QUIET_PHASE) ? 0 : IDLE_PCT;
			if (p == HOLD_PHASE)
				hold_req = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Half full-range samples, a quarter small ones and a quarter held steps.
				case ($urandom_range(3))
					0, 1: s = 16'($urandom);
					2:    s = 16'($urandom_range(511)) - 16'sd256;
					default: ;
				endcase
				send_sample(s, 1'b0, '0);
			end
		end

		settle(SETTLE_END);
		$display("Run covered %0d samples and %0d checked results over %0d coefficient settings,",
		         samples_sent, results_checked, settings_loaded);
		$display("with random gaps, an idle-free phase and a %0d-cycle output hold-off.",
		         HOLD_CYCLES);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== first_order_iir_filter_bank_top.f =====
sv/iirfb_pkg.sv
sv/first_order_iir_filter_bank_top.sv
verif/tb.sv
